// ----- sv/tes_pkg.sv -----
// shared types, constants and helpers for the terminal escape sanitizer
`timescale 1ns / 1ps
`default_nettype none

package tes_pkg;

    localparam int MAX_ESC_SEQ = 32;
    localparam int SEQ_AW      = $clog2(MAX_ESC_SEQ);
    localparam int SEQ_CW      = $clog2(MAX_ESC_SEQ + 1);

    localparam logic [7:0] CH_BEL     = 8'h07;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CH_ESC     = 8'h1b;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DEL     = 8'h7f;
    localparam logic [7:0] CH_LBRACK  = 8'h5b;
    localparam logic [7:0] CH_RBRACK  = 8'h5d;
    localparam logic [7:0] CH_UPPER_P = 8'h50;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_CARET   = 8'h5e;
    localparam logic [7:0] CH_USCORE  = 8'h5f;
    localparam logic [7:0] CH_BSLASH  = 8'h5c;
    localparam logic [7:0] CH_LOWER_M = 8'h6d;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CSI_FINAL_LO = 8'h40;
    localparam logic [7:0] CSI_FINAL_HI = 8'h7e;
    localparam logic [7:0] UTF8_LEAD_LO = 8'hc2;
    localparam logic [7:0] UTF8_LEAD_3  = 8'he0;
    localparam logic [7:0] UTF8_LEAD_4  = 8'hf0;
    localparam logic [7:0] UTF8_LEAD_HI = 8'hf4;

    localparam logic [SEQ_CW-1:0] LEN_ONE   = SEQ_CW'(1);
    localparam logic [SEQ_CW-1:0] LEN_SHORT = SEQ_CW'(2);
    localparam logic [SEQ_CW-1:0] LEN_HEX   = SEQ_CW'(4);

    typedef enum logic [2:0] {
        M_GROUND,
        M_ESC,
        M_CSI,
        M_STR,
        M_STR_ESC,
        M_UTF8
    } mode_t;

    typedef enum logic [1:0] {
        B_LIT,
        B_VIS,
        B_UTF8,
        B_CSI
    } burst_kind_t;

    typedef enum logic {
        E_IDLE,
        E_EMIT
    } emit_state_t;

    // what one input byte asks the emitter to send; len zero means nothing
    typedef struct packed {
        burst_kind_t         kind;
        logic [SEQ_CW-1:0]   len;
        logic [7:0]          val;
    } burst_t;

    typedef struct packed {
        logic                en;
        logic [SEQ_AW-1:0]   addr;
        logic [7:0]          data;
    } seq_wr_t;

    typedef struct packed {
        mode_t               mode;
        logic [SEQ_CW-1:0]   count;
        logic [1:0]          needed;
    } parse_status_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] wide;
        wide = {4'h0, n};
        if (n < 4'd10)
            hex_digit = 8'h30 + wide;
        else
            hex_digit = 8'h57 + wide;
    endfunction

endpackage

`default_nettype wire

// ----- sv/tes_parser.sv -----
// byte parser: escape, csi, control string and utf-8 state, burst selection
`timescale 1ns / 1ps
`default_nettype none

module tes_parser
    import tes_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        in_byte,
    input  wire logic              end_of_text,
    input  wire logic              color,
    output logic [3:0][7:0]        u8_bytes,
    output burst_t                 burst,
    output seq_wr_t                seq_wr,
    output parse_status_t          status
);

    mode_t                mode_reg, mode_next;
    logic [SEQ_CW-1:0]    cnt_reg, cnt_next;
    logic                 ovf_reg, ovf_next;
    logic [1:0]           need_reg, need_next;
    logic [20:0]          point_reg, point_next;
    logic [3:0][7:0]      u8_reg, u8_next;
    seq_wr_t              wr_raw;

    logic [2:0]           total;
    logic [2:0]           held3;
    logic [20:0]          point_acc;
    logic                 utf8_ok;

    always_comb
    begin
        if (u8_reg[0] >= UTF8_LEAD_4)
            total = 3'd4;
        else if (u8_reg[0] >= UTF8_LEAD_3)
            total = 3'd3;
        else
            total = 3'd2;
        held3     = total - {1'b0, need_reg};
        point_acc = {point_reg[14:0], in_byte[5:0]};
        case (total)
            3'd2:    utf8_ok = point_acc >= 21'h80;
            3'd3:    utf8_ok = point_acc >= 21'h800 &&
                               (point_acc < 21'hd800 || point_acc > 21'hdfff);
            default: utf8_ok = point_acc >= 21'h10000 && point_acc <= 21'h10ffff;
        endcase
    end

    always_comb
    begin
        logic do_ground;
        do_ground  = 1'b0;
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        need_next  = need_reg;
        point_next = point_reg;
        u8_next    = u8_reg;
        wr_raw     = '0;
        burst      = '{kind: B_LIT, len: '0, val: in_byte};

        case (mode_reg)
            M_ESC:
            begin
                if (in_byte == CH_LBRACK)
                begin
                    wr_raw    = '{en: 1'b1, addr: SEQ_AW'(1), data: in_byte};
                    cnt_next  = LEN_SHORT;
                    mode_next = M_CSI;
                end
                else if (in_byte inside {CH_RBRACK, CH_UPPER_P, CH_UPPER_X,
                                         CH_CARET, CH_USCORE})
                begin
                    cnt_next  = '0;
                    mode_next = M_STR;
                end
                else
                begin
                    cnt_next  = '0;
                    mode_next = M_GROUND;
                end
            end
            M_CSI:
            begin
                if (in_byte < CSI_FINAL_LO || in_byte > CSI_FINAL_HI)
                begin
                    if (cnt_reg < SEQ_CW'(MAX_ESC_SEQ))
                    begin
                        wr_raw   = '{en: 1'b1, addr: cnt_reg[SEQ_AW-1:0], data: in_byte};
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                        ovf_next = 1'b1;
                end
                else
                begin
                    mode_next = M_GROUND;
                    if (!ovf_reg && cnt_reg < SEQ_CW'(MAX_ESC_SEQ) && color &&
                        in_byte == CH_LOWER_M)
                    begin
                        wr_raw = '{en: 1'b1, addr: cnt_reg[SEQ_AW-1:0], data: in_byte};
                        burst  = '{kind: B_CSI, len: cnt_reg + 1'b1, val: in_byte};
                    end
                    cnt_next = '0;
                    ovf_next = 1'b0;
                end
            end
            M_STR:
            begin
                if (in_byte == CH_BEL)
                    mode_next = M_GROUND;
                else if (in_byte == CH_ESC)
                    mode_next = M_STR_ESC;
            end
            M_STR_ESC:
            begin
                if (in_byte == CH_BSLASH || in_byte == CH_BEL)
                    mode_next = M_GROUND;
                else if (in_byte != CH_ESC)
                    mode_next = M_STR;
            end
            M_UTF8:
            begin
                if (in_byte[7:6] != 2'b10)
                begin
                    // early non-continuation byte: drop the lead, reparse this one
                    mode_next  = M_GROUND;
                    need_next  = '0;
                    point_next = '0;
                    do_ground  = 1'b1;
                end
                else
                begin
                    u8_next[held3[1:0]] = in_byte;
                    point_next = point_acc;
                    need_next  = need_reg - 1'b1;
                    if (need_reg == 2'd1)
                    begin
                        mode_next  = M_GROUND;
                        point_next = '0;
                        if (utf8_ok)
                        begin
                            if (point_acc <= 21'h9f)
                                burst = '{kind: B_VIS, len: LEN_HEX, val: point_acc[7:0]};
                            else
                                burst = '{kind: B_UTF8, len: SEQ_CW'(total), val: in_byte};
                        end
                    end
                end
            end
            default:
            begin
                mode_next = M_GROUND;
                do_ground = 1'b1;
            end
        endcase

        if (do_ground)
        begin
            if (in_byte == CH_ESC)
            begin
                wr_raw    = '{en: 1'b1, addr: '0, data: in_byte};
                cnt_next  = LEN_ONE;
                ovf_next  = 1'b0;
                mode_next = M_ESC;
            end
            else if (in_byte < CH_SPACE || in_byte == CH_DEL)
            begin
                if (in_byte == CH_LF || in_byte == CH_TAB)
                    burst = '{kind: B_LIT, len: LEN_ONE, val: in_byte};
                else if (in_byte == CH_BEL || in_byte == CH_BS)
                    burst = '{kind: B_VIS, len: LEN_SHORT, val: in_byte};
                else
                    burst = '{kind: B_VIS, len: LEN_HEX, val: in_byte};
            end
            else if (in_byte[7])
            begin
                if (in_byte >= UTF8_LEAD_LO && in_byte <= UTF8_LEAD_HI)
                begin
                    u8_next[0] = in_byte;
                    mode_next  = M_UTF8;
                    if (in_byte < UTF8_LEAD_3)
                    begin
                        need_next  = 2'd1;
                        point_next = {16'h0, in_byte[4:0]};
                    end
                    else if (in_byte < UTF8_LEAD_4)
                    begin
                        need_next  = 2'd2;
                        point_next = {17'h0, in_byte[3:0]};
                    end
                    else
                    begin
                        need_next  = 2'd3;
                        point_next = {18'h0, in_byte[2:0]};
                    end
                end
            end
            else
                burst = '{kind: B_LIT, len: LEN_ONE, val: in_byte};
        end

        if (end_of_text)
        begin
            mode_next  = M_GROUND;
            cnt_next   = '0;
            ovf_next   = 1'b0;
            need_next  = '0;
            point_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_GROUND;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            need_reg  <= '0;
            point_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            need_reg  <= need_next;
            point_reg <= point_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            u8_reg <= u8_next;
    end

    assign seq_wr   = '{en: wr_raw.en & accept, addr: wr_raw.addr, data: wr_raw.data};
    assign u8_bytes = u8_reg;
    assign status   = '{mode: mode_reg, count: cnt_reg, needed: need_reg};

endmodule

`default_nettype wire

// ----- sv/tes_emit.sv -----
// output sequencer: sequence store and one-byte-per-cycle burst emitter, held while the output stalls
`timescale 1ns / 1ps
`default_nettype none

module tes_emit
    import tes_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire burst_t            burst,
    input  wire seq_wr_t           seq_wr,
    input  wire logic [3:0][7:0]   u8_bytes,
    output logic                   idle,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_byte,
    output logic                   last_of_run
);

    logic [7:0]           seq_mem [MAX_ESC_SEQ];
    logic [7:0]           rd_data_reg;
    logic [SEQ_AW-1:0]    rd_addr;

    emit_state_t          state_reg, state_next;
    burst_t               desc_reg;
    logic [SEQ_AW-1:0]    idx_reg, idx_next;
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_last_reg;

    logic                 take;
    logic                 is_last;
    logic [7:0]           cur_byte;

    assign is_last = SEQ_CW'(idx_reg) == SEQ_CW'(desc_reg.len - 1'b1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            E_IDLE:
            begin
                if (load && burst.len != '0)
                    state_next = E_EMIT;
            end
            E_EMIT:
            begin
                if (take && is_last)
                    state_next = E_IDLE;
            end
            default: state_next = E_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        idle = 1'b0;
        take = 1'b0;
        case (state_reg)
            E_IDLE:  idle = 1'b1;
            E_EMIT:  take = !out_valid_reg || out_ready;
            default: idle = 1'b0;
        endcase
    end

    always_comb
    begin
        if (state_reg != E_EMIT)
            idx_next = '0;
        else if (take)
            idx_next = is_last ? '0 : idx_reg + 1'b1;
        else
            idx_next = idx_reg;
    end

    // read one ahead so the stored byte is ready when its turn comes
    assign rd_addr = idx_next;

    always_ff @(posedge clk)
    begin
        if (seq_wr.en)
            seq_mem[seq_wr.addr] <= seq_wr.data;
        rd_data_reg <= seq_mem[rd_addr];
    end

    always_comb
    begin
        case (desc_reg.kind)
            B_LIT:  cur_byte = desc_reg.val;
            B_VIS:
            begin
                case (idx_reg[1:0])
                    2'd0:    cur_byte = CH_BSLASH;
                    2'd1:
                    begin
                        if (desc_reg.val == CH_BEL)
                            cur_byte = CH_LOWER_A;
                        else if (desc_reg.val == CH_BS)
                            cur_byte = CH_LOWER_B;
                        else
                            cur_byte = CH_LOWER_X;
                    end
                    2'd2:    cur_byte = hex_digit(desc_reg.val[7:4]);
                    default: cur_byte = hex_digit(desc_reg.val[3:0]);
                endcase
            end
            B_UTF8: cur_byte = u8_bytes[idx_reg[1:0]];
            default: cur_byte = rd_data_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (take)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && state_reg == E_IDLE)
            desc_reg <= burst;
        if (take)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;

endmodule

`default_nettype wire

// ----- sv/terminal_escape_sanitizer_core.sv -----
// top level of the terminal escape sanitizer
`timescale 1ns / 1ps
`default_nettype none

// Filters a text byte stream for terminal output. One input beat is taken only
// while the output sequencer is idle; a byte that produces output holds the
// input side until the sequencer has sent its last output byte, also while the
// output side stalls. The single output sequencer sends one byte per cycle while
// the output side is ready, from the literal, hex escape, utf-8 buffer or the
// 32-entry sequence store. color_reg resets to 1 and is written by cfg_wr_en /
// cfg_wr_data; the user must write it only while the block is idle, which the
// block itself does not enforce. There is no clearing pass after reset.
module terminal_escape_sanitizer_core
    import tes_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_wr_en,
    input  wire logic          cfg_wr_data,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    in_byte,
    input  wire logic          end_of_text,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               last_of_run
);

    logic             color_reg;
    logic             accept;
    logic             emit_idle;
    logic [3:0][7:0]  u8_bytes;
    burst_t           burst;
    seq_wr_t          seq_wr;
    parse_status_t    status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            color_reg <= 1'b1;
        else if (cfg_wr_en)
            color_reg <= cfg_wr_data;
    end

    assign in_ready = emit_idle;
    assign accept   = in_valid && emit_idle;

    tes_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .color       (color_reg),
        .u8_bytes    (u8_bytes),
        .burst       (burst),
        .seq_wr      (seq_wr),
        .status      (status)
    );

    tes_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .burst       (burst),
        .seq_wr      (seq_wr),
        .u8_bytes    (u8_bytes),
        .idle        (emit_idle),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    // a beat that produces output must close the input side next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && burst.len != '0) |=> !in_ready)
        else $error("input taken while a burst is pending");

    // a csi in progress always holds at least the esc and the bracket
    assert property (@(posedge clk) disable iff (!rst_n)
        (status.mode == M_CSI) |-> (status.count >= LEN_SHORT &&
                                    status.count <= SEQ_CW'(MAX_ESC_SEQ)))
        else $error("csi count out of range");

    // utf-8 mode always waits for at least one continuation byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (status.mode == M_UTF8) |-> (status.needed != 2'd0))
        else $error("utf-8 mode with nothing outstanding");

    // the sequence store is only written on an accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        seq_wr.en |-> accept)
        else $error("sequence store written without an input beat");

endmodule

`default_nettype wire
